/* design/fsb_pkg.sv */
// Shared types, constants and the CRC-16/MODBUS byte step for the sensor frame builder.
package fsb_pkg;

	// Frame layout.
	localparam int FRAME_BYTES = 14;
	localparam int CRC_SPAN    = 12;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [IDX_W-1:0] CRC_HI_IDX = IDX_W'(CRC_SPAN);
	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_BYTES - 1);

	// Fixed frame contents and CRC constants.
	localparam logic [7:0]  START_HI = 8'hAA;
	localparam logic [7:0]  START_LO = 8'h55;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MESSAGE_TYPE = 2'd0,
		CFG_FRAME_LENGTH = 2'd1,
		CFG_SENSOR_CODE  = 2'd2
	} cfg_reg_t;

	localparam logic [15:0] MESSAGE_TYPE_RST = 16'd0;
	localparam logic [15:0] FRAME_LENGTH_RST = 16'd10;
	localparam logic [7:0]  SENSOR_CODE_RST  = 8'd0;

	// One queued frame request: everything the back end needs to build a frame.
	typedef struct packed {
		logic [15:0] message_type;
		logic [15:0] frame_length;
		logic [7:0]  port;
		logic [7:0]  sensor_code;
		logic [31:0] value_bits;
	} frame_req_t;

	// One byte of CRC-16/MODBUS: xor in the byte, then eight reflected shifts.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

/* design/fsb_front.sv */
// Front end: holds the configuration registers and turns accepted items into frame requests.
module fsb_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fsb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                     cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [39:0]                     s_tdata,   // port[7:0], value_bits[39:8]
	input  logic                            q_full,
	output logic                            q_push,
	output fsb_pkg::frame_req_t             q_data
);
	import fsb_pkg::*;

	logic [15:0] message_type_q;
	logic [15:0] frame_length_q;
	logic [7:0]  sensor_code_q;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			message_type_q <= MESSAGE_TYPE_RST;
			frame_length_q <= FRAME_LENGTH_RST;
			sensor_code_q  <= SENSOR_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_MESSAGE_TYPE: message_type_q <= cfg_data;
				CFG_FRAME_LENGTH: frame_length_q <= cfg_data;
				CFG_SENSOR_CODE:  sensor_code_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// An item is taken whenever the queue has room.
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// Bundle the item with the current header settings.
	always_comb begin
		q_data.message_type = message_type_q;
		q_data.frame_length = frame_length_q;
		q_data.port         = s_tdata[7:0];
		q_data.sensor_code  = sensor_code_q;
		q_data.value_bits   = s_tdata[39:8];
	end

endmodule

/* design/fsb_queue.sv */
// Short queue of frame requests between the front end and the serializer.
module fsb_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fsb_pkg::frame_req_t  push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output fsb_pkg::frame_req_t  head_data
);
	import fsb_pkg::*;

	frame_req_t          mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem[rd_ptr_q];

	// Storage for queued requests.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The fill count never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	// Never pop an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	// Never push into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue pushed while full");

endmodule

/* design/fsb_back.sv */
// Back end: serializes one frame request into 14 bytes and folds the CRC in on the way.
module fsb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  fsb_pkg::frame_req_t  head_data,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // frame_byte[7:0]
	output logic                 m_tlast    // last_byte
);
	import fsb_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             last_q;

	logic [7:0]       body [CRC_SPAN];
	logic [7:0]       cur_byte;
	logic             out_free;
	logic             load;
	logic             at_last;

	// Body bytes in transmission order.
	always_comb begin
		body[0]  = START_HI;
		body[1]  = START_LO;
		body[2]  = head_data.message_type[15:8];
		body[3]  = head_data.message_type[7:0];
		body[4]  = head_data.frame_length[15:8];
		body[5]  = head_data.frame_length[7:0];
		body[6]  = head_data.port;
		body[7]  = head_data.sensor_code;
		body[8]  = head_data.value_bits[31:24];
		body[9]  = head_data.value_bits[23:16];
		body[10] = head_data.value_bits[15:8];
		body[11] = head_data.value_bits[7:0];
	end

	// Pick the byte for the current position; the trailer comes from the CRC.
	always_comb begin
		if (idx_q < CRC_HI_IDX) begin
			cur_byte = body[idx_q];
		end else if (idx_q == CRC_HI_IDX) begin
			cur_byte = crc_q[15:8];
		end else begin
			cur_byte = crc_q[7:0];
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign load     = head_valid && out_free;
	assign at_last  = (idx_q == LAST_IDX);
	assign pop      = load && at_last;

	// Position counter, running CRC and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
			byte_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (load) begin
				byte_q      <= cur_byte;
				last_q      <= at_last;
				out_valid_q <= 1'b1;
				if (at_last) begin
					idx_q <= '0;
					crc_q <= CRC_INIT;
				end else begin
					idx_q <= idx_q + 1'b1;
					if (idx_q < CRC_HI_IDX) begin
						crc_q <= crc16_byte(crc_q, cur_byte);
					end
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;

	// The position counter stays inside the frame.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("byte position past end of frame");

	// Once the final byte is loaded, the serializer is rearmed for the next frame.
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (idx_q == '0 && crc_q == CRC_INIT))
		else $error("serializer not rearmed after last byte");

	// A pop comes only with the last byte of a frame.
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid_q && last_q))
		else $error("queue popped without emitting the last byte");

endmodule

/* design/sensor_frame_builder_crc16_unit.sv */
// Top level of the sensor frame builder with CRC-16/MODBUS trailer.
// Each accepted item (port byte and raw 32-bit float pattern) yields one 14-byte frame:
// AA 55, message type, length, port, sensor code, value (all big-endian), then the
// CRC-16/MODBUS of the first 12 bytes, high byte first; tlast marks the CRC low byte.
// The serializer emits one byte per cycle from a byte-wide output register while
// m_tready is not holding it back. A two-entry request queue sits between the input
// side and the serializer; the frame being sent keeps its entry until its last byte
// is loaded, so one further item is taken while a frame is being sent. An accepted
// item is first written into the queue and its bytes then pass through the output
// register. Header settings are sampled when an item is accepted.
module sensor_frame_builder_crc16_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fsb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                     cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [39:0]                     s_tdata,   // port[7:0], value_bits[39:8]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // frame_byte[7:0]
	output logic                            m_tlast    // last_byte
);
	import fsb_pkg::*;

	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_head_valid;
	frame_req_t q_push_data;
	frame_req_t q_head_data;

	// Input side and configuration.
	fsb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_push_data)
	);

	// Request queue.
	fsb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_head_valid),
		.head_data (q_head_data)
	);

	// Frame serializer.
	fsb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_head_valid),
		.head_data (q_head_data),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
